@@ rtl/itpc_pkg.sv @@
// Shared types, codes and lookup functions for the infix-to-postfix converter.
// No dependencies; imported by every module of the block.

package itpc_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    // Stack entry codes
    localparam logic [2:0] CODE_NONE   = 3'd0;
    localparam logic [2:0] CODE_LPAREN = 3'd1;
    localparam logic [2:0] CODE_PLUS   = 3'd2;
    localparam logic [2:0] CODE_MINUS  = 3'd3;
    localparam logic [2:0] CODE_MUL    = 3'd4;
    localparam logic [2:0] CODE_DIV    = 3'd5;
    localparam logic [2:0] CODE_POW    = 3'd6;

    // Final status codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SYNTAX   = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        CLS_START    = 2'd0,
        CLS_OPERAND  = 2'd1,
        CLS_OPERATOR = 2'd2,
        CLS_PAREN    = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        EMIT_IN    = 2'd0,
        EMIT_TOP   = 2'd1,
        EMIT_FINAL = 2'd2
    } t_emit_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_FLUSH,
        S_FLUSH_FETCH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic      load_in;
        logic      emit;
        t_emit_sel emit_sel;
        logic      pop;
        logic      push;
        logic      push_lparen;
        logic      set_syntax;
        logic      set_prev;
        t_class    prev_val;
        logic      clear;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic eoe;
        logic err;
        logic is_operand;
        logic is_lparen;
        logic is_rparen;
        logic is_op;
        logic prev_operand;
        logic prev_operator;
        logic empty;
        logic top_lparen;
        logic top_pops;
        logic out_free;
    } t_stat;

    function automatic logic is_operand(input logic [7:0] c);
        is_operand = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                     (c >= "a" && c <= "z");
    endfunction

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] code;
        unique case (c)
            "+":     code = CODE_PLUS;
            "-":     code = CODE_MINUS;
            "*":     code = CODE_MUL;
            "/":     code = CODE_DIV;
            "^":     code = CODE_POW;
            default: code = CODE_NONE;
        endcase
        op_code = code;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] c;
        unique case (code)
            CODE_LPAREN: c = "(";
            CODE_PLUS:   c = "+";
            CODE_MINUS:  c = "-";
            CODE_MUL:    c = "*";
            CODE_DIV:    c = "/";
            CODE_POW:    c = "^";
            default:     c = 8'd0;
        endcase
        code_char = c;
    endfunction

    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] p;
        unique case (code)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            CODE_POW:              p = 2'd3;
            default:               p = 2'd0;
        endcase
        code_prec = p;
    endfunction

endpackage

@@ rtl/itpc_dp.sv @@
// Datapath of the infix-to-postfix converter: input latch, operator stack memory,
// expression state and the output register. Depends on itpc_pkg.

module itpc_dp #(
    parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_ch,
    input  logic              i_end_of_expr,
    input  itpc_pkg::t_cmd    i_cmd,
    output itpc_pkg::t_stat   o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_char,
    output logic              o_is_final,
    output logic [1:0]        o_status
);
    import itpc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    logic [7:0]    r_ch;
    logic          r_eoe;
    logic [CW-1:0] r_count;
    t_class        r_prev;
    logic [1:0]    r_err;
    logic [2:0]    r_top;
    logic [2:0]    r_mem [STACK_DEPTH];

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_final;
    logic [1:0]    r_out_status;

    logic [CW-1:0] w_cnt_m1;
    logic [AW-1:0] w_rd_addr;
    logic [2:0]    w_cur_code;
    logic [2:0]    w_push_code;
    logic          w_empty;
    logic          w_full;

    assign w_cur_code  = op_code(r_ch);
    assign w_push_code = i_cmd.push_lparen ? CODE_LPAREN : w_cur_code;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == FULL_CNT);
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_rd_addr   = w_empty ? '0 : w_cnt_m1[AW-1:0];

    // stack memory: one write port, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            r_mem[r_count[AW-1:0]] <= w_push_code;
        end
        r_top <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch  <= i_ch;
            r_eoe <= i_end_of_expr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= CLS_START;
            r_err   <= ERR_NONE;
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_prev  <= CLS_START;
            r_err   <= ERR_NONE;
        end else begin
            if (i_cmd.pop) begin
                r_count <= w_cnt_m1;
            end else if (i_cmd.push) begin
                if (w_full) begin
                    r_err <= ERR_OVERFLOW;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.set_syntax) begin
                r_err <= ERR_SYNTAX;
            end
            if (i_cmd.set_prev) begin
                r_prev <= i_cmd.prev_val;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (i_cmd.emit_sel)
                EMIT_IN: begin
                    r_out_char   <= r_ch;
                    r_out_final  <= 1'b0;
                    r_out_status <= ERR_NONE;
                end
                EMIT_TOP: begin
                    r_out_char   <= code_char(r_top);
                    r_out_final  <= 1'b0;
                    r_out_status <= ERR_NONE;
                end
                default: begin
                    r_out_char   <= 8'd0;
                    r_out_final  <= 1'b1;
                    r_out_status <= r_err;
                end
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_is_final = r_out_final;
    assign o_status   = r_out_status;

    always_comb begin
        o_stat.eoe           = r_eoe;
        o_stat.err           = (r_err != ERR_NONE);
        o_stat.is_operand    = is_operand(r_ch);
        o_stat.is_lparen     = (r_ch == "(");
        o_stat.is_rparen     = (r_ch == ")");
        o_stat.is_op         = (w_cur_code != CODE_NONE);
        o_stat.prev_operand  = (r_prev == CLS_OPERAND);
        o_stat.prev_operator = (r_prev == CLS_OPERATOR);
        o_stat.empty         = w_empty;
        o_stat.top_lparen    = (r_top == CODE_LPAREN);
        o_stat.top_pops      = (r_top != CODE_LPAREN) &&
                               (code_prec(r_top) >= code_prec(w_cur_code));
        o_stat.out_free      = !r_out_valid || i_ready;
    end

endmodule

@@ rtl/itpc_ctrl.sv @@
// Controller of the infix-to-postfix converter: sequences decode, pop loops and
// the end flush. Depends on itpc_pkg.

module itpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  itpc_pkg::t_stat i_stat,
    output itpc_pkg::t_cmd  o_cmd
);
    import itpc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.eoe) begin
                    if (!i_stat.err)          n_state = S_FLUSH;
                    else if (i_stat.out_free) n_state = S_IDLE;
                end else if (i_stat.err) begin
                    n_state = S_IDLE;
                end else if (i_stat.is_operand) begin
                    if (i_stat.prev_operand || i_stat.out_free) n_state = S_IDLE;
                end else if (i_stat.is_lparen) begin
                    n_state = S_IDLE;
                end else if (i_stat.is_rparen) begin
                    if (i_stat.empty || i_stat.top_lparen) n_state = S_IDLE;
                    else if (i_stat.out_free)             n_state = S_FETCH;
                end else if (i_stat.is_op && !i_stat.prev_operator) begin
                    if (!i_stat.empty && i_stat.top_pops) begin
                        if (i_stat.out_free) n_state = S_FETCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: n_state = S_EXEC;
            S_FLUSH: begin
                if (i_stat.empty) begin
                    if (i_stat.out_free) n_state = S_IDLE;
                end else if (i_stat.top_lparen || i_stat.out_free) begin
                    n_state = S_FLUSH_FETCH;
                end
            end
            S_FLUSH_FETCH: n_state = S_FLUSH;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_EXEC: begin
                if (i_stat.eoe) begin
                    if (i_stat.err && i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_FINAL;
                        o_cmd.clear    = 1'b1;
                    end
                end else if (i_stat.err) begin
                    // expression already void: drop the item
                end else if (i_stat.is_operand) begin
                    if (i_stat.prev_operand) begin
                        o_cmd.set_syntax = 1'b1;
                    end else if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_IN;
                        o_cmd.set_prev = 1'b1;
                        o_cmd.prev_val = CLS_OPERAND;
                    end
                end else if (i_stat.is_lparen) begin
                    o_cmd.push        = 1'b1;
                    o_cmd.push_lparen = 1'b1;
                    o_cmd.set_prev    = 1'b1;
                    o_cmd.prev_val    = CLS_PAREN;
                end else if (i_stat.is_rparen) begin
                    if (i_stat.empty) begin
                        o_cmd.set_syntax = 1'b1;
                        o_cmd.set_prev   = 1'b1;
                        o_cmd.prev_val   = CLS_PAREN;
                    end else if (i_stat.top_lparen) begin
                        o_cmd.pop      = 1'b1;
                        o_cmd.set_prev = 1'b1;
                        o_cmd.prev_val = CLS_PAREN;
                    end else if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_TOP;
                        o_cmd.pop      = 1'b1;
                    end
                end else if (i_stat.is_op && !i_stat.prev_operator) begin
                    if (!i_stat.empty && i_stat.top_pops) begin
                        if (i_stat.out_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EMIT_TOP;
                            o_cmd.pop      = 1'b1;
                        end
                    end else begin
                        o_cmd.push     = 1'b1;
                        o_cmd.set_prev = 1'b1;
                        o_cmd.prev_val = CLS_OPERATOR;
                    end
                end else begin
                    o_cmd.set_syntax = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.empty) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_sel = EMIT_FINAL;
                        o_cmd.clear    = 1'b1;
                    end
                end else if (i_stat.top_lparen) begin
                    o_cmd.pop        = 1'b1;
                    o_cmd.set_syntax = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EMIT_TOP;
                    o_cmd.pop      = 1'b1;
                end
            end
            S_FETCH, S_FLUSH_FETCH: begin
                // wait for the registered top-of-stack read
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/infix_to_postfix_converter.sv @@
// Top level of the infix-to-postfix converter (shunting yard, one character per item).
// Depends on itpc_pkg, itpc_ctrl and itpc_dp.
//
//   channel  | valid    | ready    | payload
//   ---------+----------+----------+------------------------------------
//   input    | i_valid  | o_ready  | i_ch, i_end_of_expr
//   output   | o_valid  | i_ready  | o_out_char, o_is_final, o_status
//
// Sequence: a character is accepted, then executed; each operator popped off
// the stack adds an emit and a registered re-read of the stack memory.
// An end marker with no error pops each stacked entry with a re-read, then the status item.
// Reset: i_rst_n synchronous, active low; clears stack count, error and class.
// The stack memory itself is not cleared; only entries below the count are used.
// Stalls: one output register; the block keeps accepting and decoding items while
// a result waits, and stalls only when it must emit into a full output register.

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_expr,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_is_final,
    output logic [1:0] o_status
);
    import itpc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing: decode, pop loops for ')' and operators, end flush
    itpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // stack memory, expression state, output register
    itpc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ch          (i_ch),
        .i_end_of_expr (i_end_of_expr),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_is_final    (o_is_final),
        .o_status      (o_status)
    );

    // status item never carries a character
    a_final_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_final |-> o_out_char == 8'd0)
        else $error("final item with nonzero character");

    // character items always report ok
    a_char_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_final |-> o_status == ERR_NONE)
        else $error("character item with nonzero status");

    // the controller never pushes and pops in the same cycle
    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_cmd.pop))
        else $error("push and pop together");

    // closing an expression leaves an empty stack and no error
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> w_stat.empty && !w_stat.err)
        else $error("state not cleared after final item");

endmodule

@@ tb/sv/itpc_postfix_checker.sv @@
// Scoreboard for the infix-to-postfix converter: predicts the postfix items
// from the accepted characters and compares them with the result channel.
// Depends on itpc_pkg for stack codes, status codes and the class enum.

module itpc_postfix_checker #(
    parameter int DEPTH = itpc_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_expr,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_is_final,
    input  logic [1:0] i_status,
    output int         o_fail_count,
    output int         o_pending
);

    import itpc_pkg::*;

    typedef struct packed {
        logic [7:0] sym;
        logic       fin;
        logic [1:0] st;
    } t_postfix_item;

    t_postfix_item postfix_due[$];
    logic [2:0]    op_stk[DEPTH];
    int            depth_now = 0;
    t_class        last_kind = CLS_START;
    logic [1:0]    err_now   = ERR_NONE;
    int            fails     = 0;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z");
    endfunction

    function automatic logic [2:0] sym_to_code(input logic [7:0] c);
        case (c)
            "+":     return CODE_PLUS;
            "-":     return CODE_MINUS;
            "*":     return CODE_MUL;
            "/":     return CODE_DIV;
            "^":     return CODE_POW;
            default: return CODE_NONE;
        endcase
    endfunction

    function automatic logic [7:0] code_to_sym(input logic [2:0] code);
        case (code)
            CODE_PLUS:  return "+";
            CODE_MINUS: return "-";
            CODE_MUL:   return "*";
            CODE_DIV:   return "/";
            CODE_POW:   return "^";
            default:    return "(";
        endcase
    endfunction

    function automatic int code_rank(input logic [2:0] code);
        case (code)
            CODE_PLUS, CODE_MINUS: return 1;
            CODE_MUL, CODE_DIV:    return 2;
            CODE_POW:              return 3;
            default:               return 0;
        endcase
    endfunction

    task automatic expect_item(input logic [7:0] sym, input logic fin, input logic [1:0] st);
        t_postfix_item it;
        it.sym = sym;
        it.fin = fin;
        it.st  = st;
        postfix_due.push_back(it);
    endtask

    task automatic stack_push(input logic [2:0] code);
        if (depth_now >= DEPTH) begin
            err_now = ERR_OVERFLOW;
        end else begin
            op_stk[depth_now] = code;
            depth_now++;
        end
    endtask

    // One accepted input item: update the parser state, queue its results.
    task automatic convert_char(input logic [7:0] c, input logic eoe);
        logic [2:0] code;
        logic [2:0] top_code;
        logic       found;
        if (eoe) begin
            if (err_now == ERR_NONE) begin
                while (depth_now > 0) begin
                    depth_now--;
                    top_code = op_stk[depth_now];
                    if (top_code == CODE_LPAREN)
                        err_now = ERR_SYNTAX;
                    else
                        expect_item(code_to_sym(top_code), 1'b0, ERR_NONE);
                end
            end
            expect_item(8'd0, 1'b1, err_now);
            depth_now = 0;
            last_kind = CLS_START;
            err_now   = ERR_NONE;
        end else if (err_now == ERR_NONE) begin
            code = sym_to_code(c);
            if (is_alnum(c)) begin
                if (last_kind == CLS_OPERAND) begin
                    err_now = ERR_SYNTAX;
                end else begin
                    expect_item(c, 1'b0, ERR_NONE);
                    last_kind = CLS_OPERAND;
                end
            end else if (c == "(") begin
                stack_push(CODE_LPAREN);
                last_kind = CLS_PAREN;
            end else if (c == ")") begin
                found = 1'b0;
                while (depth_now > 0 && !found) begin
                    depth_now--;
                    top_code = op_stk[depth_now];
                    if (top_code == CODE_LPAREN)
                        found = 1'b1;
                    else
                        expect_item(code_to_sym(top_code), 1'b0, ERR_NONE);
                end
                if (!found)
                    err_now = ERR_SYNTAX;
                last_kind = CLS_PAREN;
            end else if (code == CODE_NONE || last_kind == CLS_OPERATOR) begin
                err_now = ERR_SYNTAX;
            end else begin
                // equal precedence pops too, so ^ groups to the left
                while (depth_now > 0 && op_stk[depth_now - 1] != CODE_LPAREN &&
                       code_rank(op_stk[depth_now - 1]) >= code_rank(code)) begin
                    depth_now--;
                    expect_item(code_to_sym(op_stk[depth_now]), 1'b0, ERR_NONE);
                end
                stack_push(code);
                last_kind = CLS_OPERATOR;
            end
        end
    endtask

    always @(posedge i_clk) begin : score
        t_postfix_item want;
        if (!i_rst_n) begin
            postfix_due.delete();
            depth_now = 0;
            last_kind = CLS_START;
            err_now   = ERR_NONE;
        end else begin
            if (i_in_valid && i_in_ready)
                convert_char(i_ch, i_end_of_expr);
            if (i_out_valid && i_out_ready) begin
                if (postfix_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item char=0x%02h final=%0b status=%0d",
                             $time, i_out_char, i_is_final, i_status);
                end else begin
                    want = postfix_due.pop_front();
                    if (i_out_char !== want.sym || i_is_final !== want.fin ||
                        i_status !== want.st) begin
                        fails++;
                        $display("%0t: expected char=0x%02h final=%0b status=%0d, %s",
                                 $time, want.sym, want.fin, want.st, "actual below");
                        $display("%0t: actual   char=0x%02h final=%0b status=%0d",
                                 $time, i_out_char, i_is_final, i_status);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= postfix_due.size();
    end

endmodule

@@ tb/sv/infix_to_postfix_converter_test.sv @@
// Testbench top for the infix-to-postfix converter: drives character items
// with bursty timing and a stalling receiver, and gives the verdict.
// Depends on infix_to_postfix_converter, itpc_pkg and itpc_postfix_checker.

module infix_to_postfix_converter_test;

    localparam int ITEM_TARGET  = 230;
    // Worst correct run: ~330 items, each with a sender gap plus up to 33 results
    // held by receiver stalls, stays under this limit.
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Covers the longest flush, with room for stalls.
    localparam int DRAIN_CYCLES = 100;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_ch     = 8'd0;
    logic       in_eoe    = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_char;
    logic       out_final;
    logic [1:0] out_status;
    int         fail_count;
    int         pending;

    // Character stream of the expression being sent; end marker added on send.
    logic [7:0] text_q[$];
    int         burst_left = 0;
    int         items_sent = 0;
    int         cycles     = 0;

    always #10 clk = ~clk;

    infix_to_postfix_converter uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_ch          (in_ch),
        .i_end_of_expr (in_eoe),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_out_char    (out_char),
        .o_is_final    (out_final),
        .o_status      (out_status)
    );

    itpc_postfix_checker postfix_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_ch          (in_ch),
        .i_end_of_expr (in_eoe),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_char    (out_char),
        .i_is_final    (out_final),
        .i_status      (out_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Receiver: switches at random between stall patterns:
    // always ready, random 3 of 4, one cycle in three, long random stalls.
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;
    int phase      = 0;

    always @(posedge clk) begin : recv_pattern
        logic nxt;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
        end
        mode_left--;
        case (ready_mode)
            0: nxt = 1'b1;
            1: nxt = ($urandom_range(0, 3) != 0);
            2: begin
                phase = (phase + 1) % 3;
                nxt   = (phase == 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    nxt = 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(4, 20);
                    nxt        = 1'b0;
                end else begin
                    nxt = 1'b1;
                end
            end
        endcase
        out_ready <= nxt;
    end

    // Watchdog on a hung handshake or a lost result.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sender works in bursts; a gap drops valid only between items, and
    // within a burst valid stays high from one item to the next.
    task automatic send_item(input logic [7:0] c, input logic eoe);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 3);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_ch    <= c;
        in_eoe   <= eoe;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    // Send the text followed by an end marker carrying a random ignored ch.
    task automatic send_text(input bit counted);
        foreach (text_q[k])
            send_item(text_q[k], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        if (counted)
            items_sent += text_q.size() + 1;
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
        send_text(1'b1);
    endtask

    function automatic logic [7:0] rand_operand();
        int idx;
        idx = $urandom_range(0, 61);
        if (idx < 10)
            return 8'("0" + idx);
        else if (idx < 36)
            return 8'("A" + idx - 10);
        return 8'("a" + idx - 36);
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 4))
            0:       return "+";
            1:       return "-";
            2:       return "*";
            3:       return "/";
            default: return "^";
        endcase
    endfunction

    // Well-formed expression: operands and operators alternate, parens nest
    // up to six deep, with an occasional sign at the start or after '('.
    task automatic build_clean();
        int opens;
        int terms;
        bit want_term;
        opens     = 0;
        terms     = $urandom_range(1, 6);
        want_term = 1'b1;
        text_q.delete();
        if ($urandom_range(0, 7) == 0)
            text_q.push_back(rand_operator());
        forever begin
            if (want_term) begin
                if (opens < 6 && $urandom_range(0, 3) == 0) begin
                    text_q.push_back("(");
                    opens++;
                    if ($urandom_range(0, 5) == 0)
                        text_q.push_back(rand_operator());
                end else begin
                    text_q.push_back(rand_operand());
                    want_term = 1'b0;
                    terms--;
                end
            end else if (opens > 0 && $urandom_range(0, 2) == 0) begin
                text_q.push_back(")");
                opens--;
            end else if (terms == 0) begin
                break;
            end else begin
                text_q.push_back(rand_operator());
                want_term = 1'b1;
            end
        end
        repeat (opens) text_q.push_back(")");
    endtask

    // One random insertion or deletion in a well-formed expression.
    task automatic mutate_text();
        int         pos;
        logic [7:0] b;
        pos = $urandom_range(0, text_q.size());
        b   = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0: text_q.insert(pos, b);
            1: text_q.insert(pos, rand_operand());
            2: text_q.insert(pos, rand_operator());
            3: text_q.insert(pos, ")");
            4: text_q.insert(pos, "(");
            default: if (text_q.size() > 1) text_q.delete(pos % text_q.size());
        endcase
    endtask

    // Nesting near the stack depth: 32 entries fit, one more overflows.
    task automatic build_deep();
        int n;
        bit closed;
        text_q.delete();
        closed = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 0) begin
            n = $urandom_range(30, 34);
            repeat (n) text_q.push_back("(");
            text_q.push_back(rand_operand());
        end else begin
            // "(op" pairs: two entries each, and a long mixed flush
            n = $urandom_range(14, 17);
            repeat (n) begin
                text_q.push_back("(");
                text_q.push_back(rand_operator());
            end
            text_q.push_back(rand_operand());
        end
        if (closed)
            repeat (n) text_q.push_back(")");
    endtask

    initial begin
        logic [7:0] b;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all operators and operand extremes, a leading sign, left-grouping
        // ^, then several syntax errors, an empty one and two bad characters.
        send_string("-Z^9^A*(0-a)/z");
        send_string("ab");
        send_string("a+*b");
        send_string("a)");
        send_string("(a");
        send_string("");
        text_q.delete();
        text_q.push_back(8'h00);
        send_text(1'b1);
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text(1'b1);

        // Random: mostly well-formed, some broken, a little noise, and now and
        // then a deep nest near, at or over the stack depth.
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 99)) inside
                [0:64]: begin
                    build_clean();
                    send_text(1'b1);
                end
                [65:84]: begin
                    build_clean();
                    mutate_text();
                    send_text(1'b1);
                end
                [85:92]: begin
                    text_q.delete();
                    repeat ($urandom_range(1, 6)) begin
                        b = 8'($urandom_range(0, 255));
                        text_q.push_back(b);
                    end
                    send_text(1'b0);
                end
                default: begin
                    build_deep();
                    send_text(1'b1);
                end
            endcase
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
